// ===== rtl/core/group_survival_rate_estimator_macros.svh =====
// Assertion macros for the survival-rate estimator
`ifndef GROUP_SURVIVAL_RATE_ESTIMATOR_MACROS_SVH
`define GROUP_SURVIVAL_RATE_ESTIMATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GSRE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GSRE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GSRE_ASSERT(lbl, clk, rst_n, prop, msg)
`define GSRE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/gsre_pkg.sv =====
// ----------------------------------------------------------------------------
// gsre_pkg
// Types and constants of the group survival-rate estimator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package gsre_pkg;
  localparam int unsigned CntW  = 48;
  localparam int unsigned RateW = 17;
  localparam logic [RateW-1:0] OneQ16   = 17'd65536;
  localparam logic [RateW-1:0] HalfQ16  = 17'd32768;
  localparam logic [RateW-1:0] FloorQ16 = 17'd655;
  localparam logic [RateW-1:0] WeightRst = 17'd13107;

  typedef struct packed {
    logic [5:0]      group;
    logic [CntW-1:0] measured_before_selected;
    logic [CntW-1:0] measured_before_group;
    logic [CntW-1:0] measured_after_selected;
    logic [CntW-1:0] projected_before_selected;
    logic [CntW-1:0] projected_before_group;
    logic [CntW-1:0] projected_after_previous;
  } in_item_t;

  typedef struct packed {
    logic [5:0]       result_group;
    logic [RateW-1:0] historical_rate;
    logic [RateW-1:0] projected_rate;
    logic [RateW-1:0] last_collection_rate;
    logic             historical_updated;
    logic             projected_updated;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_READ, S_DIV_HW, S_DIV_HO, S_DIV_PR, S_DIV_PS,
    S_MUL_OW, S_BLEND_A, S_BLEND_B, S_WRITE, S_OUT
  } state_e;

  // Divider operand selects
  typedef enum logic [1:0] {
    DIV_HW, DIV_HO, DIV_PR, DIV_PS
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     clr_step;
    logic     rd;
    logic     div_start;
    div_sel_e div_sel;
    logic     div_take;
    logic     mul_ow;
    logic     blend_a;
    logic     blend_b;
    logic     wr;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic clr_done;
  } sts_t;
endpackage

// ===== rtl/core/group_survival_rate_estimator.sv =====
// ----------------------------------------------------------------------------
// group_survival_rate_estimator
// Per-group moving-average survival rates, historical and projected.
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// in        in   in_valid_i/in_ready_o  in_item_i  (in_item_t)
// out       out  out_valid_o/out_ready_i out_item_o (out_item_t)
// cfg       in   cfg_we_i               cfg_wdata_i (17 bits)
//
// Each beat runs, accept to accept: read, four 16-step divides
// on the single shared restoring divider (start, 16 steps, take; start and
// take only when the quotient saturates), weight multiply, two blends, write, load.
// After reset a clearing pass writes 1.0 into every group entry before the first
// input is taken. The result sits in an output register, so a stalled consumer
// holds back only the next beat's finish.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module group_survival_rate_estimator
  import gsre_pkg::*;
#(
  parameter int unsigned GROUP_COUNT = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_item_o,
  input  logic             cfg_we_i,
  input  logic [RateW-1:0] cfg_wdata_i
);
  logic [RateW-1:0] weight_q;
  cmd_t cmd;
  sts_t sts;

  // Weight register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) weight_q <= WeightRst;
    else if (cfg_we_i) weight_q <= cfg_wdata_i;
  end

  gsre_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd));

  gsre_dp #(.GroupCount(GROUP_COUNT)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .item_i(in_item_i),
    .weight_i(weight_q), .item_o(out_item_o));
endmodule

// ===== rtl/core/gsre_ram.sv =====
// ----------------------------------------------------------------------------
// gsre_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module gsre_ram #(
  parameter int unsigned Width = 17,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== rtl/core/gsre_div.sv =====
// ----------------------------------------------------------------------------
// gsre_div
// Saturating Q1.16 quotient, one restoring bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module gsre_div
  import gsre_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CntW-1:0]  num_i,
  input  logic [CntW-1:0]  den_i,
  output logic             busy_o,
  output logic [RateW-1:0] quot_o
);
  logic [CntW:0]    rem_q, rem_d;
  logic [CntW-1:0]  den_q;
  logic [15:0]      qb_q, qb_d;
  logic [4:0]       cnt_q;
  logic             busy_q, sat_q;
  logic [CntW+1:0]  trial;

  always_comb begin
    trial = {rem_q, 1'b0} - {2'b00, den_q};
    if (!trial[CntW+1]) begin
      rem_d = trial[CntW:0];
      qb_d  = {qb_q[14:0], 1'b1};
    end else begin
      rem_d = {rem_q[CntW-1:0], 1'b0};
      qb_d  = {qb_q[14:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= (num_i < den_i);
      cnt_q  <= 5'd16;
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 5'd1;
      busy_q <= (cnt_q != 5'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i};
      den_q <= den_i;
      qb_q  <= '0;
      sat_q <= (num_i >= den_i);
    end else if (busy_q) begin
      rem_q <= rem_d;
      qb_q  <= qb_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = sat_q ? OneQ16 : {1'b0, qb_q};
endmodule

// ===== rtl/core/gsre_ctrl.sv =====
// ----------------------------------------------------------------------------
// gsre_ctrl
// Sequencer: clear after reset; per update read, four divides, multiply, blends, write, load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "group_survival_rate_estimator_macros.svh"
module gsre_ctrl
  import gsre_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  state_e state_q, state_d;
  logic   started_q, started_d;
  logic   ovalid_q, ovalid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      started_q <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      ovalid_q  <= ovalid_d;
    end
  end

  // Run a divide: start on entry, then wait for idle
  function automatic logic div_done(logic st, logic busy);
    return st && !busy;
  endfunction

  always_comb begin
    state_d   = state_q;
    started_d = 1'b0;
    ovalid_d  = ovalid_q && !out_ready_i;
    cmd_o     = '0;
    cmd_o.div_sel = DIV_HW;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = !sts_i.clr_done;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d = S_DIV_HW;
      end
      S_DIV_HW, S_DIV_HO, S_DIV_PR, S_DIV_PS: begin
        unique case (state_q)
          S_DIV_HW: cmd_o.div_sel = DIV_HW;
          S_DIV_HO: cmd_o.div_sel = DIV_HO;
          S_DIV_PR: cmd_o.div_sel = DIV_PR;
          default:  cmd_o.div_sel = DIV_PS;
        endcase
        started_d       = 1'b1;
        cmd_o.div_start = !started_q;
        if (div_done(started_q, sts_i.div_busy)) begin
          cmd_o.div_take = 1'b1;
          started_d = 1'b0;
          unique case (state_q)
            S_DIV_HW: state_d = S_DIV_HO;
            S_DIV_HO: state_d = S_DIV_PR;
            S_DIV_PR: state_d = S_DIV_PS;
            default:  state_d = S_MUL_OW;
          endcase
        end
      end
      S_MUL_OW: begin
        cmd_o.mul_ow = 1'b1;
        state_d = S_BLEND_A;
      end
      S_BLEND_A: begin
        cmd_o.blend_a = 1'b1;
        state_d = S_BLEND_B;
      end
      S_BLEND_B: begin
        cmd_o.blend_b = 1'b1;
        state_d = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.wr = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = ovalid_q;

  `GSRE_ASSERT(a_ready_idle, clk_i, rst_ni, in_ready_o |-> state_q == S_IDLE, "ready off idle")
  `GSRE_ASSERT(a_load_ovf, clk_i, rst_ni, cmd_o.out_load |-> (!ovalid_q || out_ready_i), "output overwrite")
  `GSRE_ASSERT(a_start_quiet, clk_i, rst_ni, cmd_o.div_start |-> !sts_i.div_busy, "divider restarted while busy")
endmodule

// ===== rtl/core/gsre_dp.sv =====
// ----------------------------------------------------------------------------
// gsre_dp
// Datapath: rate stores, shared divider, multiply/blend, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module gsre_dp
  import gsre_pkg::*;
#(
  parameter int unsigned GroupCount = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  in_item_t         item_i,
  input  logic [RateW-1:0] weight_i,
  output out_item_t        item_o
);
  localparam int unsigned AW = $clog2(GroupCount);

  in_item_t         it_q;
  logic [AW-1:0]    clr_q;
  logic             clr_done_q;
  logic             inrange;
  logic [AW-1:0]    addr;
  logic [RateW-1:0] h_old, p_old, l_old;
  logic [RateW-1:0] w_q, ho_q, pr_q, ps_q, ow_q, hn_q, pn_q, ln_q;
  logic [CntW-1:0]  dnum, dden;
  logic [RateW-1:0] quot;
  logic             busy;
  logic             hu, pu;
  logic             we;
  logic [RateW-1:0] hw, pw, lw;
  logic [RateW-1:0] wt;
  logic [RateW-1:0] r_fix;
  logic [33:0]      ow_prod;
  logic [RateW-1:0] h_o, p_o;
  logic [RateW:0]   omw;
  logic [34:0]      acc;

  assign inrange = ({{(16-6){1'b0}}, it_q.group} < 16'(GroupCount));
  assign hu = inrange && (it_q.measured_before_selected != '0);
  assign pu = inrange && (it_q.projected_before_selected != '0);

  // Clear pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      clr_done_q <= 1'b0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + AW'(1);
      if (clr_q == AW'(GroupCount - 1)) clr_done_q <= 1'b1;
    end
  end
  assign sts_o.clr_done = clr_done_q;

  always_ff @(posedge clk_i) if (cmd_i.load) it_q <= item_i;

  assign addr = cmd_i.clr_step ? clr_q : AW'(it_q.group);
  assign we   = cmd_i.clr_step || (cmd_i.wr && inrange);
  assign hw = cmd_i.clr_step ? OneQ16 : (hu ? hn_q : h_old);
  assign pw = cmd_i.clr_step ? OneQ16 : (pu ? pn_q : p_old);
  assign lw = cmd_i.clr_step ? OneQ16 : (pu ? ln_q : l_old);

  gsre_ram #(.Width(RateW), .Depth(GroupCount)) u_hist (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(hw), .rdata_o(h_old));
  gsre_ram #(.Width(RateW), .Depth(GroupCount)) u_proj (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(pw), .rdata_o(p_old));
  gsre_ram #(.Width(RateW), .Depth(GroupCount)) u_last (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(lw), .rdata_o(l_old));

  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_HW: begin dnum = it_q.measured_before_selected; dden = it_q.measured_before_group; end
      DIV_HO: begin dnum = it_q.measured_after_selected; dden = it_q.measured_before_selected; end
      DIV_PR: begin dnum = it_q.measured_after_selected; dden = it_q.projected_after_previous; end
      default: begin
        dnum = it_q.projected_before_selected; dden = it_q.projected_before_group;
      end
    endcase
  end

  gsre_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(dnum), .den_i(dden),
    .busy_o(busy), .quot_o(quot));
  assign sts_o.div_busy = busy;

  // A zero divisor gives 1.0 from the saturating compare, which covers mbg and pbg.
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_take) begin
      unique case (cmd_i.div_sel)
        DIV_HW: w_q <= quot;
        DIV_HO: ho_q <= quot;
        DIV_PR: pr_q <= (it_q.projected_after_previous == '0) ? HalfQ16 : quot;
        default: ps_q <= quot;
      endcase
    end
  end

  assign wt      = (weight_i > OneQ16) ? OneQ16 : weight_i;
  assign r_fix   = (pr_q == '0) ? FloorQ16 : pr_q;
  assign ow_prod = wt * ps_q;
  assign h_o     = (h_old > OneQ16) ? OneQ16 : h_old;
  assign p_o     = (p_old > OneQ16) ? OneQ16 : p_old;

  // Blend: one pair of multiplies per step
  always_comb begin
    if (cmd_i.blend_a) begin
      omw = {1'b0, OneQ16} - {1'b0, w_q};
      acc = 35'(w_q * ho_q) + 35'(omw[RateW-1:0] * h_o);
    end else begin
      omw = {1'b0, OneQ16} - {1'b0, ow_q};
      acc = 35'(ow_q * r_fix) + 35'(omw[RateW-1:0] * p_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_ow) begin
      ow_q <= (it_q.projected_before_group == '0) ? OneQ16 : ow_prod[32:16];
      ln_q <= r_fix;
    end
    if (cmd_i.blend_a) hn_q <= acc[32:16];
    if (cmd_i.blend_b) pn_q <= acc[32:16];
    if (cmd_i.out_load) begin
      item_o.result_group         <= it_q.group;
      item_o.historical_rate      <= inrange ? (hu ? hn_q : h_old) : '0;
      item_o.projected_rate       <= inrange ? (pu ? pn_q : p_old) : '0;
      item_o.last_collection_rate <= inrange ? (pu ? ln_q : l_old) : '0;
      item_o.historical_updated   <= hu;
      item_o.projected_updated    <= pu;
    end
  end
endmodule

// ===== bench/tb_group_survival_rate_estimator.sv =====
// ----------------------------------------------------------------------------
// tb_group_survival_rate_estimator
// Self-checking bench for the survival-rate estimator: a bit-exact
// predictor of the three per-group rate stores runs beside the block,
// directed corner items and random collections are sent, and every result
// beat is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_group_survival_rate_estimator;
  import gsre_pkg::*;

  localparam int unsigned Groups = 64;
  localparam logic [RateW-1:0] WeightMax = 17'h1FFFF;
  localparam longint unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_item_o;
  logic cfg_we_i = 1'b0;
  logic [RateW-1:0] cfg_wdata_i = '0;

  group_survival_rate_estimator #(.GROUP_COUNT(Groups)) uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o, .cfg_we_i, .cfg_wdata_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: mirror of the block's stores and weight register.
  logic [RateW-1:0] hist_rate_mdl [Groups];
  logic [RateW-1:0] proj_rate_mdl [Groups];
  logic [RateW-1:0] last_rate_mdl [Groups];
  logic [RateW-1:0] obs_weight_mdl;
  out_item_t rate_results_due[$];

  int unsigned errors = 0;
  int unsigned beats_sent = 0;
  int unsigned beats_seen = 0;
  int unsigned hist_updates = 0;
  int unsigned proj_updates = 0;
  longint unsigned cycles = 0;
  bit calm = 1'b0;  // no idling on either side while set

  // Q1.16 quotient a/b saturated at 1.0
  function automatic logic [31:0] sat_quot(logic [47:0] a, logic [47:0] b);
    logic [63:0] num;
    if (b == 0 || a >= b) return 32'd65536;
    num = {a, 16'h0};
    return 32'(num / {16'h0, b});
  endfunction

  function automatic logic [RateW-1:0] blend(logic [31:0] w, logic [31:0] nv,
                                             logic [31:0] ov);
    logic [63:0] acc;
    acc = 64'(w) * 64'(nv) + 64'(32'd65536 - w) * 64'(ov);
    return acc[16 +: RateW];
  endfunction

  // Apply one collection to the mirror and return the expected beat.
  function automatic out_item_t predict_rates(in_item_t it);
    out_item_t r;
    logic [31:0] w, obs, old, pr, ow, wt;
    int g;
    r = '0;
    r.result_group = it.group;
    g = it.group;
    if (g >= Groups) return r;
    if (it.measured_before_selected != 0) begin
      w = (it.measured_before_group != 0) ?
          sat_quot(it.measured_before_selected, it.measured_before_group) : 32'd65536;
      obs = sat_quot(it.measured_after_selected, it.measured_before_selected);
      old = (hist_rate_mdl[g] > OneQ16) ? 32'd65536 : 32'(hist_rate_mdl[g]);
      hist_rate_mdl[g] = blend(w, obs, old);
      r.historical_updated = 1'b1;
    end
    if (it.projected_before_selected != 0) begin
      pr = (it.projected_after_previous != 0) ?
           sat_quot(it.measured_after_selected, it.projected_after_previous) : 32'd32768;
      if (pr == 0) pr = 32'(FloorQ16);
      last_rate_mdl[g] = pr[RateW-1:0];
      ow = 32'd65536;
      if (it.projected_before_group != 0) begin
        wt = (obs_weight_mdl > OneQ16) ? 32'd65536 : 32'(obs_weight_mdl);
        ow = 32'((64'(wt) * 64'(sat_quot(it.projected_before_selected,
                                         it.projected_before_group))) >> 16);
      end
      old = (proj_rate_mdl[g] > OneQ16) ? 32'd65536 : 32'(proj_rate_mdl[g]);
      proj_rate_mdl[g] = blend(ow, pr, old);
      r.projected_updated = 1'b1;
    end
    r.historical_rate = hist_rate_mdl[g];
    r.projected_rate = proj_rate_mdl[g];
    r.last_collection_rate = last_rate_mdl[g];
    return r;
  endfunction

  // Sender idles about 29% of the time unless calm; valid stays up between
  // back-to-back beats and drops only for an idle stretch or a drain.
  task automatic send_collection(in_item_t it);
    if (!calm && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (!calm && $urandom_range(99) < 29);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    rate_results_due.push_back(predict_rates(it));
    hist_updates += (it.measured_before_selected != 0 && it.group < Groups);
    proj_updates += (it.projected_before_selected != 0 && it.group < Groups);
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
  endtask

  // Receiver: random stall, then compare each accepted beat.
  always @(posedge clk_i) begin
    out_item_t exp_r;
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_seen++;
      if (rate_results_due.size() == 0) begin
        $error("unexpected result beat for group %0d", out_item_o.result_group);
        errors++;
      end else begin
        exp_r = rate_results_due.pop_front();
        if (out_item_o.result_group !== exp_r.result_group) begin
          $error("result_group exp %0d got %0d", exp_r.result_group,
                 out_item_o.result_group);
          errors++;
        end
        if (out_item_o.historical_rate !== exp_r.historical_rate) begin
          $error("historical_rate exp %0d got %0d", exp_r.historical_rate,
                 out_item_o.historical_rate);
          errors++;
        end
        if (out_item_o.projected_rate !== exp_r.projected_rate) begin
          $error("projected_rate exp %0d got %0d", exp_r.projected_rate,
                 out_item_o.projected_rate);
          errors++;
        end
        if (out_item_o.last_collection_rate !== exp_r.last_collection_rate) begin
          $error("last_collection_rate exp %0d got %0d",
                 exp_r.last_collection_rate, out_item_o.last_collection_rate);
          errors++;
        end
        if (out_item_o.historical_updated !== exp_r.historical_updated) begin
          $error("historical_updated exp %0b got %0b", exp_r.historical_updated,
                 out_item_o.historical_updated);
          errors++;
        end
        if (out_item_o.projected_updated !== exp_r.projected_updated) begin
          $error("projected_updated exp %0b got %0b", exp_r.projected_updated,
                 out_item_o.projected_updated);
          errors++;
        end
      end
    end
    out_ready_i <= calm || ($urandom_range(99) >= 29);
  end

  // Hard stop if the block hangs.
  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[group_survival_rate_estimator] ERROR");
      $finish;
    end
  end

  // Drain, then let the block settle before touching the weight register.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (rate_results_due.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_weight(logic [RateW-1:0] v);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    obs_weight_mdl = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()} >> 16);
  endfunction

  // Counters spread over widths so quotients land anywhere, zero included.
  function automatic logic [47:0] rand_count();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return 48'hFFFF_FFFF_FFFF;
    if (sel < 5) return 48'($urandom_range(1, 1000));
    return rand48() >> $urandom_range(0, 40);
  endfunction

  function automatic in_item_t rand_collection(bit any_group);
    in_item_t it;
    logic [47:0] sel_b;
    it.group = any_group ? 6'($urandom()) : 6'($urandom_range(0, 7));
    sel_b = rand_count();
    it.measured_before_selected = sel_b;
    // usually a proper group total and a surviving fraction
    if ($urandom_range(3) != 0) begin
      it.measured_before_group = sel_b + (rand48() >> $urandom_range(0, 47));
      it.measured_after_selected = (sel_b == 0) ? rand_count() :
                                   48'(({16'h0, sel_b} * $urandom_range(0, 1024)) >> 10);
    end else begin
      it.measured_before_group = rand_count();
      it.measured_after_selected = rand_count();
    end
    it.projected_before_selected = rand_count();
    it.projected_before_group = ($urandom_range(3) != 0) ?
        it.projected_before_selected + (rand48() >> $urandom_range(0, 47)) : rand_count();
    it.projected_after_previous = rand_count();
    return it;
  endfunction

  task automatic test_reset_weight();
    in_item_t it;
    // rates at reset, default weight
    it = '0;
    it.group = 6'd0;
    it.measured_before_selected = 48'd100;
    it.measured_before_group = 48'd400;
    it.measured_after_selected = 48'd30;
    it.projected_before_selected = 48'd100;
    it.projected_before_group = 48'd200;
    it.projected_after_previous = 48'd60;
    send_collection(it);
    // nothing selected: both rates held, stored last rate reported
    it = '0;
    it.group = 6'd63;
    it.measured_before_group = 48'hFFFF_FFFF_FFFF;
    send_collection(it);
    send_collection(it);
  endtask

  task automatic test_corners();
    in_item_t it;
    it = '1;  // all ones: every quotient saturates
    send_collection(it);
    it.group = 6'd1;
    it.measured_before_group = '0;      // no group total
    it.projected_before_group = '0;
    it.projected_after_previous = '0;   // no previous projection: 0.5
    send_collection(it);
    it = '0;
    it.group = 6'd2;
    it.measured_before_selected = 48'hFFFF_FFFF_FFFF;
    it.measured_before_group = 48'd1;   // share above group
    it.measured_after_selected = 48'd0; // zero survival, floor applies
    it.projected_before_selected = 48'd5;
    it.projected_before_group = 48'd1;
    it.projected_after_previous = 48'hFFFF_FFFF_FFFF;
    send_collection(it);
    it.measured_after_selected = 48'd1;
    send_collection(it);
    it = '0;
    it.group = 6'd3;
    it.projected_before_selected = 48'd1;
    it.projected_before_group = 48'hFFFF_FFFF_FFFF;
    it.projected_after_previous = 48'd1;
    send_collection(it);
  endtask

  task automatic test_weights();
    logic [RateW-1:0] settings [5];
    settings = '{17'd0, OneQ16, WeightMax, 17'd1, HalfQ16};
    foreach (settings[i]) begin
      write_weight(settings[i]);
      repeat (4) send_collection(rand_collection(1'b0));
    end
  endtask

  task automatic test_random_collections();
    for (int i = 0; i < 500; i++) begin
      if (i % 125 == 0 && i != 0) begin
        write_weight((i == 250) ? WeightRst : RateW'($urandom_range(0, 70000)));
      end
      calm = (i >= 300 && i < 360);  // stretch with no idling at all
      send_collection(rand_collection($urandom_range(3) == 0));
    end
    calm = 1'b0;
  endtask

  initial begin
    for (int g = 0; g < Groups; g++) begin
      hist_rate_mdl[g] = OneQ16;
      proj_rate_mdl[g] = OneQ16;
      last_rate_mdl[g] = OneQ16;
    end
    obs_weight_mdl = WeightRst;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_weight();
    test_corners();
    test_weights();
    test_random_collections();
    wait_drained();
    $display("sent %0d collections, %0d result beats checked", beats_sent, beats_seen);
    $display("historical updates %0d, projected updates %0d", hist_updates, proj_updates);
    if (errors == 0) begin
      $display("[group_survival_rate_estimator] OK");
    end else begin
      $display("[group_survival_rate_estimator] ERROR");
    end
    $finish;
  end
endmodule
